// File: design/chunked_frame_builder_crc16_core_assert.svh
// Assertion macros for the frame builder serializer (cfb_back).
`ifndef CHUNKED_FRAME_BUILDER_CRC16_CORE_ASSERT_SVH
`define CHUNKED_FRAME_BUILDER_CRC16_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CFB_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define CFB_ASSERT(name, prop, msg) \
  `CFB_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define CFB_ASSERT_CLK(name, clk, rstn, prop, msg)
`define CFB_ASSERT(name, prop, msg)
`endif

`endif

// File: design/cfb_pkg.sv
// Types, constants and the CRC step for the chunked frame builder.
package cfb_pkg;

  localparam int CHUNK_BYTES = 25;
  localparam int HDR_BYTES   = 5;
  localparam int HIDX_W      = $clog2(HDR_BYTES);
  localparam int OFF_W       = $clog2(CHUNK_BYTES + 1);
  localparam int LEN_W       = 13;
  localparam int LEN_CAP_INT = (255 * CHUNK_BYTES < 8191) ? 255 * CHUNK_BYTES : 8191;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);
  localparam int RECIP_SH    = 26;
  localparam int RECIP_W     = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] CHUNK_RECIP =
      RECIP_W'(((1 << RECIP_SH) + CHUNK_BYTES - 1) / CHUNK_BYTES);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  MSG_ID_RST = 8'd1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       trailer;
    logic       last;
    logic [7:0] ptype;
    logic [7:0] msg_id;
    logic [7:0] plen;
    logic [7:0] cidx;
    logic [7:0] ccnt;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_START,
    BS_HEAD,
    BS_DATA,
    BS_CRCH,
    BS_CRCL
  } back_state_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/cfb_front.sv
// Front end: accept message bytes, track chunking and build serializer commands.
module cfb_front import cfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic [LEN_W-1:0] message_length_i,
  input  logic [7:0]       packet_type_i,
  output cmd_t             cmd_o
);

  logic [7:0]       msg_id_q, msg_id_d;
  logic [7:0]       ltype_q, ltype_d;
  logic [LEN_W-1:0] llen_q, llen_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [7:0]       cidx_q, cidx_d;
  logic [7:0]       ccnt_q, ccnt_d;
  logic [OFF_W-1:0] off_q, off_d;

  logic                         first;
  logic [LEN_W-1:0]             len0, lenc, len_eff, remaining, pos_n;
  logic [LEN_W:0]               len_sum;
  logic [LEN_W+RECIP_W:0]       prod;
  logic [7:0]                   ccnt_new, type_eff, cnt_eff, idx_eff, plen;
  logic [OFF_W-1:0]             off_eff, off_n;
  logic                         last, trailer;

  assign first     = (pos_q == '0);
  assign len0      = (message_length_i == '0) ? LEN_W'(1) : message_length_i;
  assign lenc      = (len0 > LEN_CAP) ? LEN_CAP : len0;
  assign len_sum   = {1'b0, lenc} + (LEN_W+1)'(CHUNK_BYTES - 1);
  assign prod      = (LEN_W+RECIP_W+1)'(len_sum) * (LEN_W+RECIP_W+1)'(CHUNK_RECIP);
  assign ccnt_new  = prod[RECIP_SH+7:RECIP_SH];
  assign len_eff   = first ? lenc : llen_q;
  assign type_eff  = first ? packet_type_i : ltype_q;
  assign cnt_eff   = first ? ccnt_new : ccnt_q;
  assign idx_eff   = first ? 8'd0 : cidx_q;
  assign off_eff   = first ? '0 : off_q;
  assign remaining = len_eff - pos_q;
  assign plen      = (remaining < LEN_W'(CHUNK_BYTES)) ? remaining[7:0] : 8'(CHUNK_BYTES);
  assign pos_n     = pos_q + LEN_W'(1);
  assign off_n     = off_eff + OFF_W'(1);
  assign last      = (pos_n >= len_eff);
  assign trailer   = (off_n >= OFF_W'(CHUNK_BYTES)) || last;

  always_comb begin
    cmd_o.data    = data_byte_i;
    cmd_o.hdr     = (off_eff == '0);
    cmd_o.trailer = trailer;
    cmd_o.last    = last;
    cmd_o.ptype   = type_eff;
    cmd_o.msg_id  = msg_id_q;
    cmd_o.plen    = plen;
    cmd_o.cidx    = idx_eff;
    cmd_o.ccnt    = cnt_eff;
  end

  always_comb begin
    msg_id_d = msg_id_q;
    ltype_d  = type_eff;
    llen_d   = len_eff;
    ccnt_d   = cnt_eff;
    cidx_d   = idx_eff;
    off_d    = off_n;
    pos_d    = pos_n;
    if (trailer) begin
      off_d  = '0;
      cidx_d = idx_eff + 8'd1;
    end
    if (last) begin
      pos_d    = '0;
      msg_id_d = msg_id_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_id_q <= MSG_ID_RST;
      ltype_q  <= '0;
      llen_q   <= '0;
      pos_q    <= '0;
      cidx_q   <= '0;
      ccnt_q   <= '0;
      off_q    <= '0;
    end else if (accept_i) begin
      msg_id_q <= msg_id_d;
      ltype_q  <= ltype_d;
      llen_q   <= llen_d;
      pos_q    <= pos_d;
      cidx_q   <= cidx_d;
      ccnt_q   <= ccnt_d;
      off_q    <= off_d;
    end
  end

endmodule

// File: design/cfb_cmd_fifo.sv
// Short command queue between the front end and the serializer.
module cfb_cmd_fifo import cfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: design/cfb_back.sv
// Serializer: emit header, payload and CRC bytes into the result register.
`include "chunked_frame_builder_crc16_core_assert.svh"
module cfb_back import cfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output logic       message_end_o,
  output logic       item_done_o
);

  back_state_e       state_q, state_d;
  logic [HIDX_W-1:0] hidx_q, hidx_d;
  logic [15:0]       crc_q, crc_d;
  logic              out_valid_q;
  logic [7:0]        byte_q, byte_d;
  logic              fend_q, fend_d, mend_q, mend_d, done_q, done_d;
  logic              adv, emit, pop_cmd;
  logic [7:0]        hdr_byte;
  logic [15:0]       data_crc, hdr_crc, start_crc;

  assign adv       = !out_valid_q || pop_i;
  assign emit      = cmd_valid_i && adv;
  assign cmd_pop_o = emit && pop_cmd;

  always_comb begin
    unique case (hidx_q)
      HIDX_W'(1): hdr_byte = cmd_i.msg_id;
      HIDX_W'(2): hdr_byte = cmd_i.plen;
      HIDX_W'(3): hdr_byte = cmd_i.cidx;
      default:    hdr_byte = cmd_i.ccnt;
    endcase
  end

  assign data_crc  = crc_byte(crc_q, cmd_i.data);
  assign hdr_crc   = crc_byte(crc_q, hdr_byte);
  assign start_crc = crc_byte(CRC_INIT, cmd_i.ptype);

  always_comb begin
    state_d = state_q;
    hidx_d  = hidx_q;
    crc_d   = crc_q;
    byte_d  = cmd_i.data;
    fend_d  = 1'b0;
    mend_d  = 1'b0;
    done_d  = 1'b0;
    pop_cmd = 1'b0;
    unique case (state_q) inside
      BS_START, BS_DATA: begin
        if (state_q == BS_START && cmd_i.hdr) begin
          byte_d  = cmd_i.ptype;
          crc_d   = start_crc;
          hidx_d  = HIDX_W'(1);
          state_d = BS_HEAD;
        end else begin
          crc_d = data_crc;
          if (cmd_i.trailer) begin
            state_d = BS_CRCH;
          end else begin
            pop_cmd = 1'b1;
            done_d  = 1'b1;
            state_d = BS_START;
          end
        end
      end
      BS_HEAD: begin
        byte_d = hdr_byte;
        crc_d  = hdr_crc;
        if (hidx_q == HIDX_W'(HDR_BYTES - 1)) begin
          state_d = BS_DATA;
        end else begin
          hidx_d = hidx_q + HIDX_W'(1);
        end
      end
      BS_CRCH: begin
        byte_d  = crc_q[15:8];
        state_d = BS_CRCL;
      end
      BS_CRCL: begin
        byte_d  = crc_q[7:0];
        fend_d  = 1'b1;
        mend_d  = cmd_i.last;
        done_d  = 1'b1;
        pop_cmd = 1'b1;
        state_d = BS_START;
      end
      default: begin
        state_d = BS_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_START;
      hidx_q      <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        state_q     <= state_d;
        hidx_q      <= hidx_d;
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      fend_q <= fend_d;
      mend_q <= mend_d;
      done_q <= done_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign frame_byte_o  = byte_q;
  assign frame_end_o   = fend_q;
  assign message_end_o = mend_q;
  assign item_done_o   = done_q;

  `CFB_ASSERT(a_fend_done, out_valid_q && fend_q |-> done_q, "frame end without item done")
  `CFB_ASSERT(a_mend_fend, out_valid_q && mend_q |-> fend_q, "message end off frame end")
  `CFB_ASSERT(a_pop_emit, cmd_pop_o |-> emit && cmd_valid_i, "command popped without emit")
  `CFB_ASSERT(a_head_idx, state_q == BS_HEAD |-> hidx_q != '0, "header index out of range")

endmodule

// File: design/chunked_frame_builder_crc16_core.sv
// Chunked frame builder with CRC-16/CCITT-FALSE: top level.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+----------------------------------------------
//  input     | in        | push / full         | data_byte_i, message_length_i, packet_type_i
//  result    | out       | pop / empty         | frame_byte_o, frame_end_o, message_end_o,
//            |           |                     | item_done_o
//
// The serializer emits one result per cycle while pop does not hold it back; an item
// occupies it for its data byte, with the header before the first byte of a chunk and
// the CRC after its last.
// A two-entry command queue parts the input from the serializer; full rises when it fills.
// Reset is asynchronous and clears all control state at once; no clearing pass.
// A held result (pop low) stalls only the serializer; input flows until the queue fills.
module chunked_frame_builder_crc16_core import cfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte_i,
  input  logic [LEN_W-1:0] message_length_i,
  input  logic [7:0]       packet_type_i,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       frame_byte_o,
  output logic             frame_end_o,
  output logic             message_end_o,
  output logic             item_done_o
);

  cmd_t front_cmd, q_cmd;
  logic accept, q_valid, q_pop;

  assign accept = push && !full;

  cfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .packet_type_i    (packet_type_i),
    .cmd_o            (front_cmd)
  );

  cfb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  cfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .frame_byte_o  (frame_byte_o),
    .frame_end_o   (frame_end_o),
    .message_end_o (message_end_o),
    .item_done_o   (item_done_o)
  );

endmodule

// File: tb/sv/chunked_frame_builder_crc16_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the chunked frame builder: frame prediction, scoreboard and random traffic.

typedef struct packed {
  logic [7:0] fbyte;
  logic       fend;
  logic       mend;
  logic       idone;
} frame_result_t;

class frame_scoreboard;
  logic [7:0]    msg_id;
  logic [7:0]    lat_type;
  logic [12:0]   lat_len;
  logic [12:0]   byte_pos;
  logic [7:0]    chunk_idx;
  logic [7:0]    chunk_cnt;
  logic [4:0]    chunk_off;
  logic [15:0]   crc;
  frame_result_t held;
  bit            has_held;
  frame_result_t pending[$];
  int unsigned   mismatches;

  function new();
    msg_id     = cfb_pkg::MSG_ID_RST;
    lat_type   = '0;
    lat_len    = '0;
    byte_pos   = '0;
    chunk_idx  = '0;
    chunk_cnt  = '0;
    chunk_off  = '0;
    crc        = cfb_pkg::CRC_INIT;
    has_held   = 1'b0;
    mismatches = 0;
  endfunction

  function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ b[i]) begin
        r = {r[14:0], 1'b0} ^ cfb_pkg::CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function void queue_result(frame_result_t r);
    pending = {pending, r};
  endfunction

  function void emit(logic [7:0] b, logic fe, logic me, bit fold);
    if (has_held) begin
      queue_result(held);
    end
    held     = '{fbyte: b, fend: fe, mend: me, idone: 1'b0};
    has_held = 1'b1;
    if (fold) begin
      crc = crc_next(crc, b);
    end
  endfunction

  function void note_byte(logic [7:0] d, logic [12:0] len, logic [7:0] ptype);
    logic [12:0] l;
    logic [12:0] remaining;
    logic [7:0]  plen;
    logic        is_last;
    if (byte_pos == 0) begin
      l = len;
      if (l == 0) begin
        l = 13'd1;
      end
      if (l > cfb_pkg::LEN_CAP) begin
        l = cfb_pkg::LEN_CAP;
      end
      lat_len   = l;
      lat_type  = ptype;
      chunk_cnt = 8'((int'(l) + cfb_pkg::CHUNK_BYTES - 1) / cfb_pkg::CHUNK_BYTES);
      chunk_idx = '0;
      chunk_off = '0;
    end
    if (chunk_off == 0) begin
      remaining = lat_len - byte_pos;
      plen = (remaining < 13'(cfb_pkg::CHUNK_BYTES)) ? remaining[7:0]
                                                      : 8'(cfb_pkg::CHUNK_BYTES);
      crc  = cfb_pkg::CRC_INIT;
      emit(lat_type, 1'b0, 1'b0, 1'b1);
      emit(msg_id, 1'b0, 1'b0, 1'b1);
      emit(plen, 1'b0, 1'b0, 1'b1);
      emit(chunk_idx, 1'b0, 1'b0, 1'b1);
      emit(chunk_cnt, 1'b0, 1'b0, 1'b1);
    end
    emit(d, 1'b0, 1'b0, 1'b1);
    byte_pos  = byte_pos + 13'd1;
    chunk_off = chunk_off + 5'd1;
    is_last   = (byte_pos >= lat_len);
    if (chunk_off >= 5'(cfb_pkg::CHUNK_BYTES) || is_last) begin
      emit(crc[15:8], 1'b0, 1'b0, 1'b0);
      emit(crc[7:0], 1'b1, is_last, 1'b0);
      chunk_off = '0;
      chunk_idx = chunk_idx + 8'd1;
      if (is_last) begin
        byte_pos = '0;
        msg_id   = msg_id + 8'd1;
      end
    end
    held.idone = 1'b1;
    queue_result(held);
    has_held = 1'b0;
  endfunction

  function void check_result(logic [7:0] fb, logic fe, logic me, logic done);
    frame_result_t got;
    frame_result_t want;
    got = '{fbyte: fb, fend: fe, mend: me, idone: done};
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: byte %02h fe %0b me %0b done %0b", fb, fe, me, done);
      end
    end else begin
      want = pending.pop_front();
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch: expected byte %02h fe %0b me %0b done %0b, ",
                 want.fbyte, want.fend, want.mend, want.idone);
          $display("got byte %02h fe %0b me %0b done %0b", fb, fe, me, done);
        end
      end
    end
  endfunction
endclass

module chunked_frame_builder_crc16_core_tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_END  = 73;
  localparam int QUIET_AT    = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic [12:0] message_length_i;
  logic [7:0]  packet_type_i;
  logic        empty;
  logic        pop;
  logic [7:0]  frame_byte_o;
  logic        frame_end_o;
  logic        message_end_o;
  logic        item_done_o;

  frame_scoreboard sb;
  bit              quiet;
  int unsigned     cycles = 0;
  int unsigned     stall_left = 0;
  int unsigned     sent_items;

  chunked_frame_builder_crc16_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .packet_type_i    (packet_type_i),
    .empty            (empty),
    .pop              (pop),
    .frame_byte_o     (frame_byte_o),
    .frame_end_o      (frame_end_o),
    .message_end_o    (message_end_o),
    .item_done_o      (item_done_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_byte(data_byte_i, message_length_i, packet_type_i);
      end
      if (pop && !empty) begin
        sb.check_result(frame_byte_o, frame_end_o, message_end_o, item_done_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic push_item(input logic [7:0] d, input logic [12:0] len, input logic [7:0] ptype);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    data_byte_i      <= d;
    message_length_i <= len;
    packet_type_i    <= ptype;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items = sent_items + 1;
  endtask

  // first byte carries the given length and type; later ones carry noise there
  task automatic send_message(input logic [12:0] len, input logic [7:0] ptype,
                              input logic [7:0] first_data, input int nbytes);
    push_item(first_data, len, ptype);
    for (int i = 1; i < nbytes; i++) begin
      push_item(8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_message();
    int          r;
    int          room;
    logic [12:0] len;
    int          nbytes;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      len = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'(25 * $urandom_range(1, 2));
    end else if (r <= 6) begin
      len = 13'($urandom_range(1, 12));
    end else if (r <= 8) begin
      len = 13'($urandom_range(13, 60));
    end else begin
      len = 13'($urandom_range(24, 26));
    end
    room = RANDOM_END - int'(sent_items);
    if (room < 1) begin
      room = 1;
    end
    if (int'(len) > room) begin
      len = 13'(room);
    end
    nbytes = (len == 0) ? 1 : int'(len);
    send_message(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), nbytes);
    if (sent_items >= QUIET_AT) begin
      quiet = 1'b1;
    end
  endtask

  initial begin
    sb               = new();
    quiet            = 1'b0;
    sent_items       = 0;
    rst_ni           = 1'b0;
    push             = 1'b0;
    data_byte_i      = '0;
    message_length_i = '0;
    packet_type_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_message(13'd0, 8'h00, 8'h00, 1);
    send_message(13'd1, 8'hFF, 8'hFF, 1);
    send_message(13'd26, 8'hA5, 8'h3C, 26);

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);

    while (sent_items < RANDOM_END) begin
      send_random_message();
    end

    send_message(13'h1FFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 27);
    push <= 1'b0;
    @(posedge clk_i);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
